[hw/rtl/clss_pkg.sv]
// ----------------------------------------------------------------------------
// clss_pkg
// Shared types and codes of the circular list sequence store: request and
// status codes, datapath operations and the datapath status bundle.
// ----------------------------------------------------------------------------
package clss_pkg;

    localparam int REQ_W       = 3;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_MID  = 3'd2,
        REQ_RM_HEAD  = 3'd3,
        REQ_RM_TAIL  = 3'd4
    } req_code_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ALLOC,
        OP_INS_LINK,
        OP_WALK,
        OP_INS_NEXT,
        OP_INS_SPLICE,
        OP_RH_READ,
        OP_RH_HEAD,
        OP_RH_UNLINK,
        OP_RT_READ,
        OP_RT_START,
        OP_RT_CLOSE,
        OP_FREE,
        OP_RESP
    } dp_op_t;

    typedef struct packed {
        logic is_insert;
        logic is_rm_head;
        logic is_rm_tail;
        logic refused;
        logic empty;
        logic single;
        logic walk_done;
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/clss_req_if.sv]
// ----------------------------------------------------------------------------
// clss_req_if
// Request channel: valid/ready handshake carrying the request type and value.
// ----------------------------------------------------------------------------
interface clss_req_if;

    logic                                  valid;
    logic                                  ready;
    logic        [clss_pkg::REQ_W-1:0]     req_type;
    logic signed [clss_pkg::VALUE_W-1:0]   item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);

endinterface

[hw/rtl/clss_rsp_if.sv]
// ----------------------------------------------------------------------------
// clss_rsp_if
// Response channel: valid/ready handshake carrying removed value, count and
// status of one request.
// ----------------------------------------------------------------------------
interface clss_rsp_if;

    logic                                     valid;
    logic                                     ready;
    logic signed [clss_pkg::VALUE_W-1:0]      removed_value;
    logic        [clss_pkg::COUNT_OUT_W-1:0]  item_count;
    logic        [clss_pkg::STATUS_W-1:0]     status;

    modport source (output valid, output removed_value, output item_count,
                    output status, input ready);
    modport sink   (input valid, input removed_value, input item_count,
                    input status, output ready);

endinterface

[hw/rtl/clss_ctrl.sv]
// ----------------------------------------------------------------------------
// clss_ctrl
// Sequencer of the store: steps one request through allocation, link walk,
// splice or unlink and release, at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module clss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  clss_pkg::dp_stat_t stat,
    output clss_pkg::dp_op_t   op
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'd1,
        S_DECODE     = 14'd2,
        S_ALLOC      = 14'd4,
        S_INS_LINK   = 14'd8,
        S_INS_WALK   = 14'd16,
        S_INS_SPLICE = 14'd32,
        S_RH_READ    = 14'd64,
        S_RH_HEAD    = 14'd128,
        S_RH_UNLINK  = 14'd256,
        S_RT_READ    = 14'd512,
        S_RT_START   = 14'd1024,
        S_RT_WALK    = 14'd2048,
        S_FREE       = 14'd4096,
        S_RESP       = 14'd8192
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = clss_pkg::OP_NONE;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op         = clss_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (stat.refused)
                    state_next = S_RESP;
                else if (stat.is_insert)
                    state_next = S_ALLOC;
                else if (stat.is_rm_head)
                    state_next = S_RH_READ;
                else if (stat.is_rm_tail)
                    state_next = S_RT_READ;
                else
                    state_next = S_RESP;
            end
            S_ALLOC:
            begin
                op         = clss_pkg::OP_ALLOC;
                state_next = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                op         = clss_pkg::OP_INS_LINK;
                state_next = stat.empty ? S_RESP : S_INS_WALK;
            end
            S_INS_WALK:
            begin
                if (stat.walk_done)
                begin
                    op         = clss_pkg::OP_INS_NEXT;
                    state_next = S_INS_SPLICE;
                end
                else
                begin
                    op = clss_pkg::OP_WALK;
                end
            end
            S_INS_SPLICE:
            begin
                op         = clss_pkg::OP_INS_SPLICE;
                state_next = S_RESP;
            end
            S_RH_READ:
            begin
                op         = clss_pkg::OP_RH_READ;
                state_next = S_RH_HEAD;
            end
            S_RH_HEAD:
            begin
                op         = clss_pkg::OP_RH_HEAD;
                state_next = S_RH_UNLINK;
            end
            S_RH_UNLINK:
            begin
                op         = clss_pkg::OP_RH_UNLINK;
                state_next = S_FREE;
            end
            S_RT_READ:
            begin
                op         = clss_pkg::OP_RT_READ;
                state_next = S_RT_START;
            end
            S_RT_START:
            begin
                op         = clss_pkg::OP_RT_START;
                state_next = stat.single ? S_FREE : S_RT_WALK;
            end
            S_RT_WALK:
            begin
                if (stat.walk_done)
                begin
                    op         = clss_pkg::OP_RT_CLOSE;
                    state_next = S_FREE;
                end
                else
                begin
                    op = clss_pkg::OP_WALK;
                end
            end
            S_FREE:
            begin
                op         = clss_pkg::OP_FREE;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    op         = clss_pkg::OP_RESP;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/clss_dp.sv]
// ----------------------------------------------------------------------------
// clss_dp
// Datapath of the store: value and link memories, tail, count and free
// chain pointers, walk registers and the response output register.
// ----------------------------------------------------------------------------
module clss_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  clss_pkg::dp_op_t                         op,
    output clss_pkg::dp_stat_t                       stat,
    input  logic        [clss_pkg::REQ_W-1:0]        req_type,
    input  logic signed [clss_pkg::VALUE_W-1:0]      item_value,
    input  logic                                     rsp_ready,
    output logic                                     rsp_valid,
    output logic signed [clss_pkg::VALUE_W-1:0]      removed_value,
    output logic        [clss_pkg::COUNT_OUT_W-1:0]  item_count,
    output logic        [clss_pkg::STATUS_W-1:0]     status
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VW     = clss_pkg::VALUE_W;
    localparam int OCW    = clss_pkg::COUNT_OUT_W;

    // memories
    logic [SLOT_W-1:0] link_mem  [CAPACITY];
    logic [VW-1:0]     value_mem [CAPACITY];

    logic              lnk_we;
    logic [SLOT_W-1:0] lnk_wa;
    logic [SLOT_W-1:0] lnk_wd;
    logic              lnk_re;
    logic [SLOT_W-1:0] lnk_ra;
    logic              val_we;
    logic [SLOT_W-1:0] val_wa;
    logic              val_re;
    logic [SLOT_W-1:0] val_ra;

    logic [SLOT_W-1:0] link_rd_reg;
    logic [VW-1:0]     value_rd_reg;

    // control state
    logic [SLOT_W-1:0] tail_reg,      tail_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [SLOT_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0]  fresh_reg,     fresh_next;
    logic              out_valid_reg, out_valid_next;

    // working registers
    logic [clss_pkg::REQ_W-1:0]  req_reg,     req_next;
    logic [VW-1:0]               val_reg,     val_next;
    logic [SLOT_W-1:0]           slot_reg,    slot_next;
    logic [SLOT_W-1:0]           cur_reg,     cur_next;
    logic [SLOT_W-1:0]           head_reg,    head_next;
    logic [CNT_W-1:0]            steps_reg,   steps_next;
    logic                        pop_reg,     pop_next;
    logic [VW-1:0]               removed_reg, removed_next;
    clss_pkg::status_t           status_reg,  status_next;
    logic [VW-1:0]               out_value_reg,  out_value_next;
    logic [OCW-1:0]              out_count_reg,  out_count_next;
    logic [clss_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    logic              recycled;
    logic [SLOT_W-1:0] alloc_slot;
    logic              full;
    logic              empty;
    logic              single;
    logic [CNT_W:0]    half_sum;
    logic [CNT_W-1:0]  mid_steps;
    logic [CNT_W+OCW-1:0] count_wide;
    logic              in_insert;
    logic              in_remove;
    logic              is_ins_tail;
    logic              is_ins_mid;

    assign recycled   = (fresh_reg != count_reg);
    assign alloc_slot = recycled ? free_head_reg : fresh_reg[SLOT_W-1:0];
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign single     = (count_reg == CNT_W'(1));
    assign half_sum   = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign mid_steps  = half_sum[CNT_W:1];
    assign count_wide = {{OCW{1'b0}}, count_reg};

    assign in_insert = (req_type == clss_pkg::REQ_INS_HEAD) ||
                       (req_type == clss_pkg::REQ_INS_TAIL) ||
                       (req_type == clss_pkg::REQ_INS_MID);
    assign in_remove = (req_type == clss_pkg::REQ_RM_HEAD) ||
                       (req_type == clss_pkg::REQ_RM_TAIL);

    assign is_ins_tail = (req_reg == clss_pkg::REQ_INS_TAIL);
    assign is_ins_mid  = (req_reg == clss_pkg::REQ_INS_MID);

    assign stat.is_insert  = (req_reg == clss_pkg::REQ_INS_HEAD) || is_ins_tail || is_ins_mid;
    assign stat.is_rm_head = (req_reg == clss_pkg::REQ_RM_HEAD);
    assign stat.is_rm_tail = (req_reg == clss_pkg::REQ_RM_TAIL);
    assign stat.refused    = (status_reg != clss_pkg::ST_DONE);
    assign stat.empty      = empty;
    assign stat.single     = single;
    assign stat.walk_done  = (steps_reg == '0);
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    always_comb
    begin
        tail_next       = tail_reg;
        count_next      = count_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        req_next        = req_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        steps_next      = steps_reg;
        pop_next        = pop_reg;
        removed_next    = removed_reg;
        status_next     = status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        lnk_we = 1'b0;
        lnk_wa = slot_reg;
        lnk_wd = slot_reg;
        lnk_re = 1'b0;
        lnk_ra = tail_reg;
        val_we = 1'b0;
        val_wa = alloc_slot;
        val_re = 1'b0;
        val_ra = tail_reg;
        unique case (op)
            clss_pkg::OP_LATCH:
            begin
                req_next     = req_type;
                val_next     = item_value;
                removed_next = '0;
                priority if (in_insert && full)
                    status_next = clss_pkg::ST_FULL;
                else if (in_remove && empty)
                    status_next = clss_pkg::ST_EMPTY;
                else
                    status_next = clss_pkg::ST_DONE;
            end
            clss_pkg::OP_ALLOC:
            begin
                slot_next = alloc_slot;
                pop_next  = recycled;
                val_we    = 1'b1;
                val_wa    = alloc_slot;
                if (recycled)
                begin
                    lnk_re = 1'b1;
                    lnk_ra = free_head_reg;
                end
                else
                begin
                    fresh_next = fresh_reg + CNT_W'(1);
                end
            end
            clss_pkg::OP_INS_LINK:
            begin
                if (pop_reg)
                    free_head_next = link_rd_reg;
                if (empty)
                begin
                    // first element closes a ring on itself
                    lnk_we     = 1'b1;
                    lnk_wa     = slot_reg;
                    lnk_wd     = slot_reg;
                    tail_next  = slot_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    lnk_re     = 1'b1;
                    lnk_ra     = tail_reg;
                    cur_next   = tail_reg;
                    steps_next = is_ins_mid ? mid_steps : '0;
                end
            end
            clss_pkg::OP_WALK:
            begin
                cur_next   = link_rd_reg;
                lnk_re     = 1'b1;
                lnk_ra     = link_rd_reg;
                steps_next = steps_reg - CNT_W'(1);
            end
            clss_pkg::OP_INS_NEXT:
            begin
                lnk_we = 1'b1;
                lnk_wa = slot_reg;
                lnk_wd = link_rd_reg;
            end
            clss_pkg::OP_INS_SPLICE:
            begin
                lnk_we = 1'b1;
                lnk_wa = cur_reg;
                lnk_wd = slot_reg;
                if (is_ins_tail || (is_ins_mid && (cur_reg == tail_reg)))
                    tail_next = slot_reg;
                count_next = count_reg + CNT_W'(1);
            end
            clss_pkg::OP_RH_READ:
            begin
                lnk_re = 1'b1;
                lnk_ra = tail_reg;
            end
            clss_pkg::OP_RH_HEAD:
            begin
                slot_next = link_rd_reg;
                lnk_re    = 1'b1;
                lnk_ra    = link_rd_reg;
                val_re    = 1'b1;
                val_ra    = link_rd_reg;
            end
            clss_pkg::OP_RH_UNLINK:
            begin
                removed_next = value_rd_reg;
                if (!single)
                begin
                    lnk_we = 1'b1;
                    lnk_wa = tail_reg;
                    lnk_wd = link_rd_reg;
                end
            end
            clss_pkg::OP_RT_READ:
            begin
                slot_next = tail_reg;
                lnk_re    = 1'b1;
                lnk_ra    = tail_reg;
                val_re    = 1'b1;
                val_ra    = tail_reg;
            end
            clss_pkg::OP_RT_START:
            begin
                removed_next = value_rd_reg;
                head_next    = link_rd_reg;
                cur_next     = link_rd_reg;
                lnk_re       = 1'b1;
                lnk_ra       = link_rd_reg;
                steps_next   = count_reg - CNT_W'(2);
            end
            clss_pkg::OP_RT_CLOSE:
            begin
                lnk_we    = 1'b1;
                lnk_wa    = cur_reg;
                lnk_wd    = head_reg;
                tail_next = cur_reg;
            end
            clss_pkg::OP_FREE:
            begin
                lnk_we         = 1'b1;
                lnk_wa         = slot_reg;
                lnk_wd         = free_head_reg;
                free_head_next = slot_reg;
                count_next     = count_reg - CNT_W'(1);
            end
            clss_pkg::OP_RESP:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = removed_reg;
                out_count_next  = count_wide[OCW-1:0];
                out_status_next = status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lnk_we)
            link_mem[lnk_wa] <= lnk_wd;
        if (lnk_re)
            link_rd_reg <= link_mem[lnk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
            value_mem[val_wa] <= val_reg;
        if (val_re)
            value_rd_reg <= value_mem[val_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg      <= '0;
            count_reg     <= '0;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        slot_reg       <= slot_next;
        cur_reg        <= cur_next;
        head_reg       <= head_next;
        steps_reg      <= steps_next;
        pop_reg        <= pop_next;
        removed_reg    <= removed_next;
        status_reg     <= status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign rsp_valid     = out_valid_reg;
    assign removed_value = out_value_reg;
    assign item_count    = out_count_reg;
    assign status        = out_status_reg;

endmodule

[hw/rtl/circular_list_sequence_store.sv]
// ----------------------------------------------------------------------------
// circular_list_sequence_store
// Bounded ordered store of signed values kept as a singly linked circular
// list with a tail pointer, a count and a free chain of released slots.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    req_type, item_value
//   rsp      out  valid/ready    removed_value, item_count, status
//
// one request at a time: an insert allocates a slot, links it and, unless the
//   store was empty, walks to its predecessor (halfway round for the middle)
//   and splices it in; remove head unlinks the head, remove tail walks to
//   the new tail and closes the ring, both freeing the slot; the walk reads
//   one link per cycle from the link memory read port
// no clearing pass after reset: slots are handed out from a fill mark
// a response waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module circular_list_sequence_store #(
    parameter int CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    clss_req_if.sink   req,
    clss_rsp_if.source rsp
);

    clss_pkg::dp_op_t   op;
    clss_pkg::dp_stat_t stat;

    clss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .op        (op)
    );

    clss_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .stat          (stat),
        .req_type      (req.req_type),
        .item_value    (req.item_value),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .removed_value (rsp.removed_value),
        .item_count    (rsp.item_count),
        .status        (rsp.status)
    );

endmodule

[hw/rtl/clss_checker.sv]
// ----------------------------------------------------------------------------
// clss_checker
// Port-level checks of the store, attached to the top level by bind.
// ----------------------------------------------------------------------------
module clss_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     req_ready,
    input logic                                     rsp_valid,
    input logic                                     rsp_ready,
    input logic signed [clss_pkg::VALUE_W-1:0]      removed_value,
    input logic        [clss_pkg::COUNT_OUT_W-1:0]  item_count,
    input logic        [clss_pkg::STATUS_W-1:0]     status
);

    localparam logic [clss_pkg::COUNT_OUT_W-1:0] CAP_LOW = clss_pkg::COUNT_OUT_W'(CAPACITY);

    // stalled response keeps its contents
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(removed_value) &&
                                    $stable(item_count) && $stable(status))
        else $error("response dropped or changed under stall");

    // a refused insert reports a full store
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == clss_pkg::ST_FULL) |-> item_count == CAP_LOW)
        else $error("full refusal with wrong count");

    // a refused remove reports an empty store and no value
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == clss_pkg::ST_EMPTY) |->
            (item_count == '0) && (removed_value == '0))
        else $error("empty refusal with count or value");

    // a new response is only raised while the request side is closed
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response raised while idle");

endmodule

bind circular_list_sequence_store clss_checker #(
    .CAPACITY (CAPACITY)
) u_clss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .removed_value (rsp.removed_value),
    .item_count    (rsp.item_count),
    .status        (rsp.status)
);
